// ----- rtl/core/c8alu_pkg.sv -----
// shared types and constants for the 8-bit add / decimal-adjust alu slice
`timescale 1ns / 1ps

package c8alu_pkg;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 32;

    typedef enum logic [2:0] {
        OP_ADD_A   = 3'd0,
        OP_ADC_A   = 3'd1,
        OP_ADD_HL  = 3'd2,
        OP_ADD_SP  = 3'd3,
        OP_CCF     = 3'd4,
        OP_SCF     = 3'd5,
        OP_CPL     = 3'd6,
        OP_DAA     = 3'd7
    } t_op;

    // declared high field first so the operation lands in bit 0 of tdata
    typedef struct packed {
        logic        pad;
        logic        carry_in;
        logic        half_in;
        logic        subtract_in;
        logic        zero_in;
        logic [15:0] operand16;
        logic [7:0]  operand8;
        logic [15:0] pair_in;
        logic [7:0]  acc_in;
        t_op         operation;
    } t_alu_in;

    typedef struct packed {
        logic [3:0]  pad;
        logic        carry_out;
        logic        half_out;
        logic        subtract_out;
        logic        zero_out;
        logic [15:0] pair_out;
        logic [7:0]  acc_out;
    } t_alu_out;

    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0] DAA_LO_LIM = 4'h9;

endpackage

// ----- rtl/core/c8alu_core.sv -----
// combinational add, flag and decimal-adjust logic for one instruction
`timescale 1ns / 1ps

module c8alu_core import c8alu_pkg::*; (
    input  t_alu_in  i_in,
    output t_alu_out o_out
);

    logic        cin;
    logic [8:0]  sum8;
    logic [4:0]  sum4;
    logic [16:0] sum16;
    logic [12:0] sum12;
    logic [8:0]  sp_lo8;
    logic [4:0]  sp_lo4;
    logic [15:0] sp_sum;
    logic [7:0]  adj;
    logic        daa_c;
    logic [7:0]  daa_acc;

    always_comb begin
        cin    = (i_in.operation == OP_ADC_A) ? i_in.carry_in : 1'b0;
        sum8   = {1'b0, i_in.acc_in} + {1'b0, i_in.operand8} + {8'd0, cin};
        sum4   = {1'b0, i_in.acc_in[3:0]} + {1'b0, i_in.operand8[3:0]} + {4'd0, cin};
        sum16  = {1'b0, i_in.pair_in} + {1'b0, i_in.operand16};
        sum12  = {1'b0, i_in.pair_in[11:0]} + {1'b0, i_in.operand16[11:0]};
        // flags of add sp come from the unsigned low-byte add
        sp_lo8 = {1'b0, i_in.pair_in[7:0]} + {1'b0, i_in.operand8};
        sp_lo4 = {1'b0, i_in.pair_in[3:0]} + {1'b0, i_in.operand8[3:0]};
        sp_sum = i_in.pair_in + {{8{i_in.operand8[7]}}, i_in.operand8};

        // decimal adjust, both tests on the original accumulator
        adj   = 8'd0;
        daa_c = i_in.carry_in;
        if (i_in.half_in || (!i_in.subtract_in && (i_in.acc_in[3:0] > DAA_LO_LIM))) begin
            adj = adj | DAA_LO_ADJ;
        end
        if (i_in.carry_in || (!i_in.subtract_in && (i_in.acc_in > DAA_HI_LIM))) begin
            adj   = adj | DAA_HI_ADJ;
            daa_c = 1'b1;
        end
        daa_acc = i_in.subtract_in ? (i_in.acc_in - adj) : (i_in.acc_in + adj);
    end

    always_comb begin
        o_out              = '0;
        o_out.acc_out      = i_in.acc_in;
        o_out.pair_out     = i_in.pair_in;
        o_out.zero_out     = i_in.zero_in;
        o_out.subtract_out = i_in.subtract_in;
        o_out.half_out     = i_in.half_in;
        o_out.carry_out    = i_in.carry_in;
        case (i_in.operation)
            OP_ADD_A, OP_ADC_A: begin
                o_out.acc_out      = sum8[7:0];
                o_out.zero_out     = (sum8[7:0] == 8'd0);
                o_out.subtract_out = 1'b0;
                o_out.half_out     = sum4[4];
                o_out.carry_out    = sum8[8];
            end
            OP_ADD_HL: begin
                o_out.pair_out     = sum16[15:0];
                o_out.subtract_out = 1'b0;
                o_out.half_out     = sum12[12];
                o_out.carry_out    = sum16[16];
            end
            OP_ADD_SP: begin
                o_out.pair_out     = sp_sum;
                o_out.zero_out     = 1'b0;
                o_out.subtract_out = 1'b0;
                o_out.half_out     = sp_lo4[4];
                o_out.carry_out    = sp_lo8[8];
            end
            OP_CCF: begin
                o_out.subtract_out = 1'b0;
                o_out.half_out     = 1'b0;
                o_out.carry_out    = ~i_in.carry_in;
            end
            OP_SCF: begin
                o_out.subtract_out = 1'b0;
                o_out.half_out     = 1'b0;
                o_out.carry_out    = 1'b1;
            end
            OP_CPL: begin
                o_out.acc_out      = ~i_in.acc_in;
                o_out.subtract_out = 1'b1;
                o_out.half_out     = 1'b1;
            end
            OP_DAA: begin
                o_out.acc_out   = daa_acc;
                o_out.zero_out  = (daa_acc == 8'd0);
                o_out.half_out  = 1'b0;
                o_out.carry_out = daa_c;
            end
            default: begin
                o_out.acc_out = i_in.acc_in;
            end
        endcase
    end

endmodule

// ----- rtl/core/cpu8_add_daa_flag_alu.sv -----
// top level: input register, alu logic and result register on stream ports
`timescale 1ns / 1ps

// 8-bit cpu alu slice (add, adc, 16-bit adds, ccf, scf, cpl, daa) behind
// stream ports. One instruction is taken every clock cycle while the output
// is not stalled, and each gives exactly one result. An instruction passes
// through the input register and then the result register, with the alu logic
// between them. When the output stalls, the pipeline holds and still takes one
// more instruction into the input register.

module cpu8_add_daa_flag_alu import c8alu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // operation, acc_in, pair_in, operand8, operand16, zero_in, subtract_in,
    // half_in, carry_in, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // acc_out, pair_out, zero_out, subtract_out, half_out, carry_out, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic     r_in_valid;
    t_alu_in  r_in_data;
    logic     r_out_valid;
    t_alu_out r_out_data;
    t_alu_out alu_res;
    logic     advance;
    logic     n_in_valid;
    logic     n_out_valid;

    c8alu_core u_core (
        .i_in  (r_in_data),
        .o_out (alu_res)
    );

    always_comb begin
        advance     = !r_out_valid || i_m_tready;
        o_s_tready  = !r_in_valid || advance;
        n_in_valid  = o_s_tready ? i_s_tvalid : r_in_valid;
        n_out_valid = advance ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= t_alu_in'(i_s_tdata);
        end
        if (advance && r_in_valid) begin
            r_out_data <= alu_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- rtl/core/c8alu_checker.sv -----
// port-level checks for the alu slice, bound to the top level
`timescale 1ns / 1ps

module c8alu_checker import c8alu_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // the input side only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input not ready without output stall");

    // a result transfer frees room for a new instruction
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready |-> o_s_tready)
        else $error("input not ready while result drains");

    // padding bits of a result stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[31:28] == 4'd0)
        else $error("result padding not zero");

endmodule

bind cpu8_add_daa_flag_alu c8alu_checker u_c8alu_checker (.*);
